FILE: hdl/scaled_matrix_multiply_accumulate_macros.svh
// assertion macros for the scaled matrix multiply-accumulate block
`ifndef SCALED_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define SCALED_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SMMA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`define SMMA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SMMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SMMA_ASSERT_NEVER(lbl, cond, msg)

`define SMMA_ASSERT_IMPLIES(lbl, ante, cons, msg)

`define SMMA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/smma_pkg.sv
// shared constants, types and helper functions of the matrix multiply-accumulate block
package smma_pkg;

    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 16;
    localparam int FRAC_BITS  = ELEM_WIDTH - 4;

    localparam int DIM_LIM  = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int CNT_BITS = $clog2(DIM_LIM);
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam int POS_W     = 3;
    localparam int DIM_W     = 4;
    localparam int SCALE_W   = 16;
    localparam int IN_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIM_W-1:0]          DIM_RESET   = 4'd8;
    localparam logic signed [SCALE_W-1:0] ALPHA_RESET = 16'sd6144;
    localparam logic signed [SCALE_W-1:0] BETA_RESET  = 16'sd4915;

    // datapath widths, capped at 64 bits where the sums wrap
    localparam int PROD_W  = 2 * ELEM_WIDTH;
    localparam int DOT_RAW = 2 * ELEM_WIDTH + CNT_BITS;
    localparam int DOT_W   = (DOT_RAW > 64) ? 64 : DOT_RAW;
    localparam int AD_RAW  = SCALE_W + DOT_W;
    localparam int AD_W    = (AD_RAW > 64) ? 64 : AD_RAW;
    localparam int BC_RAW  = SCALE_W + ELEM_WIDTH;
    localparam int BC_W    = (BC_RAW > 64) ? 64 : BC_RAW;
    localparam int TOT_MAX = (AD_W > BC_W + FRAC_BITS) ? AD_W : BC_W + FRAC_BITS;
    localparam int TOT_W   = (TOT_MAX + 1 > 64) ? 64 : TOT_MAX + 1;
    localparam int SH_W    = TOT_W - 2 * FRAC_BITS;

    typedef enum logic [1:0] {
        OP_WRITE_A,
        OP_WRITE_B,
        OP_WRITE_C,
        OP_RUN
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS,
        REG_COLS,
        REG_INNER,
        REG_ALPHA,
        REG_BETA
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

    typedef struct packed {
        logic                  done;
        logic [ELEM_WIDTH-1:0] result;
    } mac_stat_t;

    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] c;
    } rd_addr_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     addr;
        logic [ELEM_WIDTH-1:0] data;
    } wb_t;

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [POS_W-1:0] r,
                                                    input logic [POS_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
    endfunction

    // highest index in use for a dimension register, held within 0 .. DIM_LIM-1
    function automatic logic [CNT_BITS-1:0] last_index(input logic [DIM_W-1:0] d);
        if (d == '0)
        begin
            return '0;
        end
        else if (int'(d) > DIM_LIM)
        begin
            return CNT_BITS'(DIM_LIM - 1);
        end
        else
        begin
            return CNT_BITS'(d - 1'b1);
        end
    endfunction

endpackage

FILE: hdl/smma_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module smma_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= store_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/smma_mac.sv
// shared multiply-accumulate pipeline with alpha/beta scaling and saturation
module smma_mac import smma_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mac_ctrl_t                 issue,
    input  logic [ELEM_WIDTH-1:0]     a_data,
    input  logic [ELEM_WIDTH-1:0]     b_data,
    input  logic [ELEM_WIDTH-1:0]     c_data,
    input  logic signed [SCALE_W-1:0] alpha,
    input  logic signed [SCALE_W-1:0] beta,
    output mac_stat_t                 stat
);

    logic v1_reg, f1_reg, l1_reg;
    logic v2_reg, f2_reg, l2_reg;
    logic v3_reg, v4_reg, v5_reg;

    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [DOT_W-1:0]      acc_reg;
    logic signed [ELEM_WIDTH-1:0] c_reg;
    logic signed [AD_W-1:0]       ad_reg;
    logic signed [BC_W-1:0]       bc_reg;
    logic [ELEM_WIDTH-1:0]        res_reg;

    logic signed [DOT_W-1:0]  prod_ext;
    logic signed [TOT_W-1:0]  total;
    logic signed [SH_W-1:0]   shifted;
    logic [ELEM_WIDTH-1:0]    sat;

    // control flags follow the read data down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            f1_reg <= 1'b0;
            l1_reg <= 1'b0;
            v2_reg <= 1'b0;
            f2_reg <= 1'b0;
            l2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue.valid;
            f1_reg <= issue.first;
            l1_reg <= issue.last;
            v2_reg <= v1_reg;
            f2_reg <= f1_reg;
            l2_reg <= l1_reg;
            v3_reg <= v2_reg && l2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign prod_ext = DOT_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= $signed(a_data) * $signed(b_data);
        end
        if (v1_reg && f1_reg)
        begin
            c_reg <= $signed(c_data);
        end
        if (v2_reg)
        begin
            acc_reg <= f2_reg ? prod_ext : acc_reg + prod_ext;
        end
        if (v3_reg)
        begin
            ad_reg <= AD_W'(alpha) * AD_W'(acc_reg);
            bc_reg <= BC_W'(beta) * BC_W'(c_reg);
        end
        if (v4_reg)
        begin
            res_reg <= sat;
        end
    end

    assign total   = TOT_W'(ad_reg) + (TOT_W'(bc_reg) <<< FRAC_BITS);
    assign shifted = SH_W'(total >>> (2 * FRAC_BITS));

    generate
        if (SH_W > ELEM_WIDTH)
        begin : g_sat
            always_comb
            begin
                if ((&shifted[SH_W-1:ELEM_WIDTH-1]) || !(|shifted[SH_W-1:ELEM_WIDTH-1]))
                begin
                    sat = shifted[ELEM_WIDTH-1:0];
                end
                else if (shifted[SH_W-1])
                begin
                    sat = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
                end
                else
                begin
                    sat = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
                end
            end
        end
        else
        begin : g_ext
            assign sat = ELEM_WIDTH'(shifted);
        end
    endgenerate

    assign stat.done   = v5_reg;
    assign stat.result = res_reg;

endmodule

FILE: hdl/smma_ctrl.sv
// run sequencer: index counters, store read addresses, write-back and output register
module smma_ctrl import smma_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       opcode,
    input  logic [DIM_W-1:0] rows_used,
    input  logic [DIM_W-1:0] cols_used,
    input  logic [DIM_W-1:0] inner_used,
    input  mac_stat_t        stat,
    output mac_ctrl_t        issue,
    output rd_addr_t         raddr,
    output wb_t              wb,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [POS_W-1:0] out_row,
    output logic [POS_W-1:0] out_col,
    output logic [IN_W-1:0]  out_value,
    output logic             last
);

    state_t state_reg, state_next;

    logic [CNT_BITS-1:0] i_reg, i_next;
    logic [CNT_BITS-1:0] j_reg, j_next;
    logic [CNT_BITS-1:0] k_reg, k_next;
    logic [CNT_BITS-1:0] li_reg, li_next;
    logic [CNT_BITS-1:0] lj_reg, lj_next;
    logic [CNT_BITS-1:0] lk_reg, lk_next;

    logic out_valid_reg, out_valid_next;
    logic [POS_W-1:0]      out_row_reg;
    logic [POS_W-1:0]      out_col_reg;
    logic [ELEM_WIDTH-1:0] out_value_reg;
    logic                  out_last_reg;

    logic slot_free;
    logic out_load;

    assign slot_free = !out_valid_reg || out_ready;

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        li_next    = li_reg;
        lj_next    = lj_reg;
        lk_next    = lk_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (opcode_t'(opcode) == OP_RUN))
                begin
                    li_next    = last_index(rows_used);
                    lj_next    = last_index(cols_used);
                    lk_next    = last_index(inner_used);
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (k_reg == lk_reg)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (slot_free)
                begin
                    if (j_reg == lj_reg)
                    begin
                        j_next = '0;
                        if (i_reg == li_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        issue.valid = 1'b0;
        issue.first = (k_reg == '0);
        issue.last  = (k_reg == lk_reg);
        raddr.a     = elem_addr(POS_W'(i_reg), POS_W'(k_reg));
        raddr.b     = elem_addr(POS_W'(k_reg), POS_W'(j_reg));
        raddr.c     = elem_addr(POS_W'(i_reg), POS_W'(j_reg));
        wb.we       = 1'b0;
        wb.addr     = elem_addr(POS_W'(i_reg), POS_W'(j_reg));
        wb.data     = stat.result;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_READ:
            begin
                issue.valid = 1'b1;
            end
            ST_WAIT:
            begin
            end
            ST_PUSH:
            begin
                wb.we = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    assign out_load       = wb.we;
    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            li_reg        <= '0;
            lj_reg        <= '0;
            lk_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            li_reg        <= li_next;
            lj_reg        <= lj_next;
            lk_reg        <= lk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg   <= POS_W'(i_reg);
            out_col_reg   <= POS_W'(j_reg);
            out_value_reg <= stat.result;
            out_last_reg  <= (i_reg == li_reg) && (j_reg == lj_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = IN_W'($signed(out_value_reg));
    assign last      = out_last_reg;

endmodule

FILE: hdl/scaled_matrix_multiply_accumulate.sv
// top level of the scaled matrix multiply-accumulate block, c = beta*c + alpha*a*b
//
//   channel   dir   handshake            fields
//   input     in    in_valid / in_ready  opcode, row, col, value
//   output    out   out_valid/out_ready  out_row, out_col, out_value, last
//   config    in    cfg_we               cfg_index, cfg_data
//
// a write request emits nothing
// a run request reads, for each element, inner pairs through one read port per store
// into one shared multiplier, then scales the sum in the pipeline and writes it back
// no clearing pass after reset; the element stores hold anything until written
// an output stall holds the run at write-back until the output register is free
`include "scaled_matrix_multiply_accumulate_macros.svh"

module scaled_matrix_multiply_accumulate import smma_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [POS_W-1:0]      row,
    input  logic [POS_W-1:0]      col,
    input  logic signed [IN_W-1:0] value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [POS_W-1:0]      out_row,
    output logic [POS_W-1:0]      out_col,
    output logic signed [IN_W-1:0] out_value,
    output logic                  last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic [DIM_W-1:0]          rows_used_reg;
    logic [DIM_W-1:0]          cols_used_reg;
    logic [DIM_W-1:0]          inner_used_reg;
    logic signed [SCALE_W-1:0] alpha_reg;
    logic signed [SCALE_W-1:0] beta_reg;

    logic                  load_we;
    logic [ADDR_W-1:0]     load_addr;
    logic [ELEM_WIDTH-1:0] load_data;
    logic                  a_we, b_we, c_we;
    logic [ADDR_W-1:0]     c_waddr;
    logic [ELEM_WIDTH-1:0] c_wdata;
    logic [ELEM_WIDTH-1:0] a_rdata, b_rdata, c_rdata;

    mac_ctrl_t issue;
    mac_stat_t stat;
    rd_addr_t  raddr;
    wb_t       wb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg  <= DIM_RESET;
            cols_used_reg  <= DIM_RESET;
            inner_used_reg <= DIM_RESET;
            alpha_reg      <= ALPHA_RESET;
            beta_reg       <= BETA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROWS:  rows_used_reg  <= cfg_data[DIM_W-1:0];
                REG_COLS:  cols_used_reg  <= cfg_data[DIM_W-1:0];
                REG_INNER: inner_used_reg <= cfg_data[DIM_W-1:0];
                REG_ALPHA: alpha_reg      <= $signed(cfg_data[SCALE_W-1:0]);
                REG_BETA:  beta_reg       <= $signed(cfg_data[SCALE_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    // element writes outside the store are dropped
    assign load_we   = in_valid && in_ready && (opcode_t'(opcode) != OP_RUN)
                       && (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
    assign load_addr = elem_addr(row, col);
    assign load_data = ELEM_WIDTH'(value);

    assign a_we    = load_we && (opcode_t'(opcode) == OP_WRITE_A);
    assign b_we    = load_we && (opcode_t'(opcode) == OP_WRITE_B);
    assign c_we    = (load_we && (opcode_t'(opcode) == OP_WRITE_C)) || wb.we;
    assign c_waddr = wb.we ? wb.addr : load_addr;
    assign c_wdata = wb.we ? wb.data : load_data;

    smma_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH)) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (load_addr),
        .wdata (load_data),
        .raddr (raddr.a),
        .rdata (a_rdata)
    );

    smma_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH)) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (load_addr),
        .wdata (load_data),
        .raddr (raddr.b),
        .rdata (b_rdata)
    );

    smma_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH)) u_c_store (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (raddr.c),
        .rdata (c_rdata)
    );

    smma_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .c_data (c_rdata),
        .alpha  (alpha_reg),
        .beta   (beta_reg),
        .stat   (stat)
    );

    smma_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .rows_used  (rows_used_reg),
        .cols_used  (cols_used_reg),
        .inner_used (inner_used_reg),
        .stat       (stat),
        .issue      (issue),
        .raddr      (raddr),
        .wb         (wb),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .last       (last)
    );

    `SMMA_ASSERT_NEVER(a_c_write_clash, wb.we && load_we, "write-back clashes with element write")
    `SMMA_ASSERT_IMPLIES(a_wb_while_busy, wb.we, !in_ready, "write-back while requests are taken")
    `SMMA_ASSERT_NEXT(a_out_matches_wb, wb.we, out_valid && (out_value == $past(IN_W'($signed(wb.data)))), "output differs from written-back element")

endmodule
